// ===== rtl/buddy_page_allocator_unit_defines.svh =====
// Assertion macros used by the buddy page allocator checker.
`ifndef BUDDY_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

// Checks a consequent in the same cycle as its antecedent.
`define BPA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("buddy allocator assertion failed");

// Checks a consequent in the cycle after its antecedent.
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("buddy allocator assertion failed");

`endif

// ===== rtl/bpa_pkg.sv =====
// Types and constants shared by the buddy page allocator modules.
package bpa_pkg;

	localparam int PAGE_COUNT = 16384;
	localparam int TOP_ORDER  = 10;
	localparam int PW         = 14;
	localparam int LW         = PW + 1;
	localparam int OW         = 4;
	localparam int BW         = 5;
	localparam int MW         = OW + 1;
	localparam int MAX_BLOCKS = PAGE_COUNT >> TOP_ORDER;

	typedef logic [LW-1:0] link_t;
	typedef logic [PW-1:0] page_t;
	typedef logic [OW-1:0] ord_t;

	localparam link_t NIL_LINK    = LW'(PAGE_COUNT);
	localparam link_t BLOCK_PAGES = LW'(1 << TOP_ORDER);
	localparam ord_t  TOP_ORD     = OW'(TOP_ORDER);

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef struct packed {
		ord_t ord;
		logic free;
	} meta_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_NOMEM  = 2'd1,
		STAT_REJECT = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_POP_RD,
		S_POP_WR,
		S_SPLIT,
		S_PUSH,
		S_PUSH_LINK,
		S_ALLOC_FIN,
		S_FREE_RD,
		S_FREE_CHK,
		S_MRG_RD,
		S_MRG_CHK,
		S_UNLINK_CLR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic  active;
		page_t addr;
		link_t next_link;
		link_t prev_link;
		meta_t meta;
	} sweep_t;

endpackage

// ===== rtl/bpa_ram.sv =====
// Generic single write port RAM with one registered read port.
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wa,
	input  logic [WIDTH-1:0]         wd,
	input  logic [$clog2(DEPTH)-1:0] ra,
	output logic [WIDTH-1:0]         rd
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	assign rd = rd_q;

endmodule

// ===== rtl/bpa_init.sv =====
// Pool size register and the sweep that rebuilds the page tables.
module bpa_init import bpa_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [BW-1:0] cfg_wr_data,
	output sweep_t        sweep,
	output link_t         pool_pages
);

	logic [BW-1:0] blocks_q;
	logic [BW-1:0] blocks_clamped;
	logic          active_q;
	page_t         addr_q;
	link_t         addr_link;
	link_t         next_cand;
	logic          aligned;
	logic          in_pool;

	always_comb begin
		if (cfg_wr_data == '0) begin
			blocks_clamped = BW'(1);
		end else if (cfg_wr_data > BW'(MAX_BLOCKS)) begin
			blocks_clamped = BW'(MAX_BLOCKS);
		end else begin
			blocks_clamped = cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_q <= BW'(MAX_BLOCKS);
			active_q <= 1'b1;
			addr_q   <= '0;
		end else if (cfg_wr_en) begin
			blocks_q <= blocks_clamped;
			active_q <= 1'b1;
			addr_q   <= '0;
		end else if (active_q) begin
			addr_q <= addr_q + PW'(1);
			if (addr_q == PW'(PAGE_COUNT - 1)) begin
				active_q <= 1'b0;
			end
		end
	end

	assign pool_pages = LW'(blocks_q) << TOP_ORDER;
	assign addr_link  = {1'b0, addr_q};
	assign next_cand  = addr_link + BLOCK_PAGES;
	assign aligned    = (addr_q[TOP_ORDER-1:0] == '0);
	assign in_pool    = (addr_link < pool_pages);

	always_comb begin
		sweep.active    = active_q;
		sweep.addr      = addr_q;
		sweep.next_link = (aligned && next_cand < pool_pages) ? next_cand : NIL_LINK;
		sweep.prev_link = (aligned && in_pool && addr_q != '0) ?
			(addr_link - BLOCK_PAGES) : NIL_LINK;
		sweep.meta.ord  = TOP_ORD;
		sweep.meta.free = in_pool;
	end

endmodule

// ===== rtl/buddy_page_allocator_unit.sv =====
// Buddy page allocator: one request at a time, stepped over the link tables by a sequencer.
// The pool holds up to 16 blocks of 1024 pages. An allocate scans the orders upward for a
// non-empty list, pops its head, splits it down to the asked order pushing each upper half,
// and marks the block taken; a free reads the block, then at each level reads the buddy and
// unlinks and merges it while it is free at that order, and last pushes the merged block.
// Each list push, pop and unlink is split into steps, since every link table has a single
// write port. After reset and after every write of the pool size the tables are rebuilt by
// a sweep over all 16384 pages, one page a cycle, during which no request is taken.
module buddy_page_allocator_unit import bpa_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [BW-1:0] cfg_wr_data,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          kind,
	input  logic [OW-1:0] order,
	input  logic [PW-1:0] page_index,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    status,
	output logic [PW-1:0] block_page,
	output logic [OW-1:0] block_order
);

	state_t  state_q, state_d;
	sweep_t  sweep;
	link_t   pool_pages;
	link_t   heads_q [TOP_ORDER+1];

	logic    kind_q;
	ord_t    ord_q;
	ord_t    k_q;
	page_t   p_q;
	page_t   x_q;
	link_t   h_q;
	status_t res_status_q;
	page_t   res_page_q;
	ord_t    res_order_q;

	logic    out_valid_q;
	status_t out_status_q;
	page_t   out_page_q;
	ord_t    out_order_q;

	logic    accept;
	logic    bad_order;
	page_t   in_page_aligned;
	logic    in_pool;
	page_t   buddy;
	page_t   split_buddy;
	logic    merge_ok;
	logic    out_load;
	link_t   head_k;

	logic    nx_we, pv_we, mt_we;
	page_t   nx_wa, pv_wa, mt_wa, ra;
	link_t   nx_wd, pv_wd;
	meta_t   mt_wd;
	logic    fnx_we, fpv_we, fmt_we;
	page_t   fnx_wa, fpv_wa, fmt_wa;
	link_t   fnx_wd, fpv_wd;
	meta_t   fmt_wd;
	link_t   next_rd, prev_rd;
	logic [MW-1:0] meta_raw;
	meta_t   meta_rd;

	bpa_init u_init (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.sweep      (sweep),
		.pool_pages (pool_pages)
	);

	assign in_stall        = sweep.active || (state_q != S_IDLE);
	assign accept          = in_valid && !in_stall;
	assign bad_order       = (order > TOP_ORD);
	assign in_page_aligned = page_index & (PW'({PW{1'b1}}) << order);
	assign in_pool         = ({1'b0, in_page_aligned} < pool_pages);
	assign buddy           = p_q ^ (PW'(1) << k_q);
	assign split_buddy     = p_q ^ (PW'(1) << (k_q - OW'(1)));
	assign meta_rd         = meta_t'(meta_raw);
	assign merge_ok        = (meta_rd.ord == k_q) && meta_rd.free;
	assign out_load        = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign head_k          = heads_q[k_q];

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (bad_order || (kind == KIND_FREE && !in_pool)) begin
						state_d = S_DONE;
					end else if (kind == KIND_ALLOC) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_FREE_RD;
					end
				end
			end
			S_SCAN: begin
				if (head_k != NIL_LINK) begin
					state_d = S_POP_RD;
				end else if (k_q == TOP_ORD) begin
					state_d = S_DONE;
				end
			end
			S_POP_RD:    state_d = S_POP_WR;
			S_POP_WR:    state_d = S_SPLIT;
			S_SPLIT:     state_d = (k_q == ord_q) ? S_ALLOC_FIN : S_PUSH;
			S_PUSH:      state_d = S_PUSH_LINK;
			S_PUSH_LINK: state_d = (kind_q == KIND_FREE) ? S_DONE : S_SPLIT;
			S_ALLOC_FIN: state_d = S_DONE;
			S_FREE_RD:   state_d = S_FREE_CHK;
			S_FREE_CHK:  state_d = meta_rd.free ? S_DONE : S_MRG_RD;
			S_MRG_RD:    state_d = (k_q == TOP_ORD) ? S_PUSH : S_MRG_CHK;
			S_MRG_CHK:   state_d = merge_ok ? S_UNLINK_CLR : S_PUSH;
			S_UNLINK_CLR: state_d = S_MRG_RD;
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		fnx_we = 1'b0;
		fnx_wa = '0;
		fnx_wd = NIL_LINK;
		fpv_we = 1'b0;
		fpv_wa = '0;
		fpv_wd = NIL_LINK;
		fmt_we = 1'b0;
		fmt_wa = '0;
		fmt_wd = '{ord: k_q, free: 1'b1};
		ra     = p_q;
		case (state_q)
			S_POP_WR: begin
				fnx_we = 1'b1;
				fnx_wa = p_q;
				if (next_rd != NIL_LINK) begin
					fpv_we = 1'b1;
					fpv_wa = next_rd[PW-1:0];
				end
			end
			S_PUSH: begin
				fmt_we = 1'b1;
				fmt_wa = x_q;
				fnx_we = 1'b1;
				fnx_wa = x_q;
				fnx_wd = head_k;
				fpv_we = 1'b1;
				fpv_wa = x_q;
			end
			S_PUSH_LINK: begin
				if (h_q != NIL_LINK) begin
					fpv_we = 1'b1;
					fpv_wa = h_q[PW-1:0];
					fpv_wd = {1'b0, x_q};
				end
			end
			S_ALLOC_FIN: begin
				fmt_we = 1'b1;
				fmt_wa = p_q;
				fmt_wd = '{ord: ord_q, free: 1'b0};
			end
			S_MRG_RD: begin
				ra = buddy;
			end
			S_MRG_CHK: begin
				if (merge_ok) begin
					fmt_we = 1'b1;
					fmt_wa = buddy;
					fmt_wd = '{ord: k_q, free: 1'b0};
					if (prev_rd != NIL_LINK) begin
						fnx_we = 1'b1;
						fnx_wa = prev_rd[PW-1:0];
						fnx_wd = next_rd;
					end
					if (next_rd != NIL_LINK) begin
						fpv_we = 1'b1;
						fpv_wa = next_rd[PW-1:0];
						fpv_wd = prev_rd;
					end
				end
			end
			S_UNLINK_CLR: begin
				fnx_we = 1'b1;
				fnx_wa = buddy;
				fpv_we = 1'b1;
				fpv_wa = buddy;
			end
			default: begin
				ra = p_q;
			end
		endcase
	end

	always_comb begin
		if (sweep.active) begin
			nx_we = 1'b1;
			nx_wa = sweep.addr;
			nx_wd = sweep.next_link;
			pv_we = 1'b1;
			pv_wa = sweep.addr;
			pv_wd = sweep.prev_link;
			mt_we = 1'b1;
			mt_wa = sweep.addr;
			mt_wd = sweep.meta;
		end else begin
			nx_we = fnx_we;
			nx_wa = fnx_wa;
			nx_wd = fnx_wd;
			pv_we = fpv_we;
			pv_wa = fpv_wa;
			pv_wd = fpv_wd;
			mt_we = fmt_we;
			mt_wa = fmt_wa;
			mt_wd = fmt_wd;
		end
	end

	bpa_ram #(.WIDTH(LW), .DEPTH(PAGE_COUNT)) u_next_ram (
		.clk(clk), .we(nx_we), .wa(nx_wa), .wd(nx_wd), .ra(ra), .rd(next_rd)
	);

	bpa_ram #(.WIDTH(LW), .DEPTH(PAGE_COUNT)) u_prev_ram (
		.clk(clk), .we(pv_we), .wa(pv_wa), .wd(pv_wd), .ra(ra), .rd(prev_rd)
	);

	bpa_ram #(.WIDTH(MW), .DEPTH(PAGE_COUNT)) u_meta_ram (
		.clk(clk), .we(mt_we), .wa(mt_wa), .wd(MW'(mt_wd)), .ra(ra), .rd(meta_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i <= TOP_ORDER; i++) begin
				heads_q[i] <= (i == TOP_ORDER) ? '0 : NIL_LINK;
			end
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				for (int i = 0; i <= TOP_ORDER; i++) begin
					heads_q[i] <= (i == TOP_ORDER) ? '0 : NIL_LINK;
				end
			end else begin
				case (state_q)
					S_POP_WR:  heads_q[k_q] <= next_rd;
					S_PUSH:    heads_q[k_q] <= {1'b0, x_q};
					S_MRG_CHK: begin
						if (merge_ok && prev_rd == NIL_LINK) begin
							heads_q[k_q] <= next_rd;
						end
					end
					default: begin
						heads_q[k_q] <= head_k;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				kind_q       <= kind;
				ord_q        <= order;
				k_q          <= order;
				p_q          <= in_page_aligned;
				res_status_q <= STAT_REJECT;
				res_page_q   <= '0;
				res_order_q  <= '0;
			end
			S_SCAN: begin
				if (head_k != NIL_LINK) begin
					p_q <= head_k[PW-1:0];
				end else if (k_q == TOP_ORD) begin
					res_status_q <= STAT_NOMEM;
				end else begin
					k_q <= k_q + OW'(1);
				end
			end
			S_SPLIT: begin
				if (k_q != ord_q) begin
					k_q <= k_q - OW'(1);
					x_q <= split_buddy;
				end
			end
			S_PUSH: begin
				h_q <= head_k;
			end
			S_PUSH_LINK: begin
				if (kind_q == KIND_FREE) begin
					res_status_q <= STAT_OK;
					res_page_q   <= x_q;
					res_order_q  <= k_q;
				end
			end
			S_ALLOC_FIN: begin
				res_status_q <= STAT_OK;
				res_page_q   <= p_q;
				res_order_q  <= ord_q;
			end
			S_MRG_RD: begin
				x_q <= p_q;
			end
			S_UNLINK_CLR: begin
				if (buddy < p_q) begin
					p_q <= buddy;
				end
				k_q <= k_q + OW'(1);
			end
			default: begin
				x_q <= x_q;
			end
		endcase
		if (out_load) begin
			out_status_q <= res_status_q;
			out_page_q   <= res_page_q;
			out_order_q  <= res_order_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign block_page  = out_page_q;
	assign block_order = out_order_q;

endmodule

// ===== rtl/bpa_checker.sv =====
// Port-level checker for the buddy page allocator, bound to its top level.
`include "buddy_page_allocator_unit_defines.svh"

module bpa_checker import bpa_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	input logic          cfg_wr_en,
	input logic [BW-1:0] cfg_wr_data,
	input logic          in_valid,
	input logic          in_stall,
	input logic          kind,
	input logic [OW-1:0] order,
	input logic [PW-1:0] page_index,
	input logic          out_valid,
	input logic          out_stall,
	input logic [1:0]    status,
	input logic [PW-1:0] block_page,
	input logic [OW-1:0] block_order
);

	`BPA_ASSERT_NEXT(a_cfg_starts_sweep, cfg_wr_en, in_stall)
	`BPA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`BPA_ASSERT_NOW(a_fail_zero_payload, out_valid && status != STAT_OK, block_page == '0 && block_order == '0)
	`BPA_ASSERT_NOW(a_ok_order_range, out_valid && status == STAT_OK, block_order <= TOP_ORD)
	`BPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(block_page) && $stable(status))

endmodule

bind buddy_page_allocator_unit bpa_checker u_bpa_checker (.*);
